FILE: hw/rtl/rmutex_pkg.sv
// shared types and constants for the recursive mutex block
// no dependencies; imported by every rtl module of the block

package rmutex_pkg;

    localparam int TID_W      = 4;
    localparam int STATUS_W   = 4;
    localparam int NEST_OUT_W = 8;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED    = 4'd0,
        ST_NESTED     = 4'd1,
        ST_QUEUED     = 4'd2,
        ST_NEST_REL   = 4'd3,
        ST_FREED      = 4'd4,
        ST_HANDOFF    = 4'd5,
        ST_NOT_HOLDER = 4'd6,
        ST_DUP_WAIT   = 4'd7,
        ST_OVERFLOW   = 4'd8
    } status_t;

    // queue command from the lock control, tid doubles as lookup key
    typedef struct packed {
        logic             push;
        logic             pop;
        logic [TID_W-1:0] tid;
    } queue_cmd_t;

    // queue status back to the lock control
    typedef struct packed {
        logic             empty;
        logic             full;
        logic             waiting;
        logic [TID_W-1:0] head_tid;
    } queue_stat_t;

    // one result as it leaves the block
    typedef struct packed {
        status_t               status;
        logic                  woken_valid;
        logic [TID_W-1:0]      woken_thread;
        logic                  owner_valid;
        logic [TID_W-1:0]      owner_thread;
        logic [NEST_OUT_W-1:0] nest_count;
    } result_t;

endpackage

FILE: hw/rtl/rmutex_queue.sv
// fifo of waiting threads with a per-thread waiting bit
// depends on rmutex_pkg

module rmutex_queue #(
    parameter int THREAD_COUNT = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rmutex_pkg::queue_cmd_t   cmd,
    output rmutex_pkg::queue_stat_t  stat
);
    import rmutex_pkg::*;

    localparam int IDX_W = $clog2(THREAD_COUNT);
    localparam int CNT_W = $clog2(THREAD_COUNT + 1);
    localparam int SUM_W = IDX_W + 1;

    logic [TID_W-1:0]        mem [THREAD_COUNT];
    logic [TID_W-1:0]        rd_reg;
    logic [IDX_W-1:0]        head_reg;
    logic [IDX_W-1:0]        head_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [THREAD_COUNT-1:0] waiting_reg;
    logic [THREAD_COUNT-1:0] waiting_next;
    logic [SUM_W-1:0]        tail_sum;
    logic [IDX_W-1:0]        tail_slot;

    // tail slot, wrapped once since head + count stays below twice the depth
    always_comb
    begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (tail_sum >= SUM_W'(THREAD_COUNT))
        begin
            tail_slot = IDX_W'(tail_sum - SUM_W'(THREAD_COUNT));
        end
        else
        begin
            tail_slot = IDX_W'(tail_sum);
        end
    end

    // head, count and waiting bits next values
    always_comb
    begin
        head_next    = head_reg;
        count_next   = count_reg;
        waiting_next = waiting_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
            waiting_next[IDX_W'(cmd.tid)] = 1'b1;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
            waiting_next[IDX_W'(rd_reg)] = 1'b0;
            if (head_reg == IDX_W'(THREAD_COUNT - 1))
            begin
                head_next = '0;
            end
            else
            begin
                head_next = head_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            count_reg   <= '0;
            waiting_reg <= '0;
        end
        else
        begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            waiting_reg <= waiting_next;
        end
    end

    // waiter memory write port
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[tail_slot] <= cmd.tid;
        end
    end

    // registered read of the next head entry, with write forwarding
    always_ff @(posedge clk)
    begin
        if (cmd.push && (tail_slot == head_next))
        begin
            rd_reg <= cmd.tid;
        end
        else
        begin
            rd_reg <= mem[head_next];
        end
    end

    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg >= CNT_W'(THREAD_COUNT));
    assign stat.waiting  = waiting_reg[IDX_W'(cmd.tid)];
    assign stat.head_tid = rd_reg;

endmodule

FILE: hw/rtl/rmutex_ctrl.sv
// lock owner state, request decision and result register
// depends on rmutex_pkg

module rmutex_ctrl #(
    parameter int THREAD_COUNT = 16,
    parameter int MAX_NESTING  = 255
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic                            req_action,
    input  logic [rmutex_pkg::TID_W-1:0]    req_tid,
    input  rmutex_pkg::queue_stat_t         qstat,
    output rmutex_pkg::queue_cmd_t          qcmd,
    output logic                            res_valid,
    output rmutex_pkg::result_t             res
);
    import rmutex_pkg::*;

    localparam int NEST_W = $clog2(MAX_NESTING + 1);

    logic              held_reg;
    logic              held_next;
    logic [TID_W-1:0]  holder_reg;
    logic [TID_W-1:0]  holder_next;
    logic [NEST_W-1:0] nest_reg;
    logic [NEST_W-1:0] nest_next;
    logic              res_valid_reg;
    result_t           res_reg;
    result_t           res_next;
    status_t           st;
    logic              woke;
    logic              in_range;
    logic              is_holder;

    assign in_range  = (32'(req_tid) < THREAD_COUNT);
    assign is_holder = held_reg && (holder_reg == req_tid);

    // request decision
    always_comb
    begin
        held_next   = held_reg;
        holder_next = holder_reg;
        nest_next   = nest_reg;
        st          = ST_NOT_HOLDER;
        woke        = 1'b0;
        qcmd.push   = 1'b0;
        qcmd.pop    = 1'b0;
        qcmd.tid    = req_tid;
        if (!in_range)
        begin
            st = ST_NOT_HOLDER;
        end
        else if (!req_action)
        begin
            // acquire
            if (is_holder)
            begin
                if (nest_reg >= NEST_W'(MAX_NESTING))
                begin
                    st = ST_OVERFLOW;
                end
                else
                begin
                    nest_next = nest_reg + NEST_W'(1);
                    st        = ST_NESTED;
                end
            end
            else if (qstat.waiting)
            begin
                st = ST_DUP_WAIT;
            end
            else if (!held_reg)
            begin
                held_next   = 1'b1;
                holder_next = req_tid;
                nest_next   = NEST_W'(1);
                st          = ST_GRANTED;
            end
            else if (qstat.full)
            begin
                st = ST_DUP_WAIT;
            end
            else
            begin
                qcmd.push = req_valid;
                st        = ST_QUEUED;
            end
        end
        else
        begin
            // release
            if (!is_holder)
            begin
                st = ST_NOT_HOLDER;
            end
            else if (nest_reg > NEST_W'(1))
            begin
                nest_next = nest_reg - NEST_W'(1);
                st        = ST_NEST_REL;
            end
            else if (qstat.empty)
            begin
                held_next   = 1'b0;
                holder_next = '0;
                nest_next   = '0;
                st          = ST_FREED;
            end
            else
            begin
                qcmd.pop    = req_valid;
                holder_next = qstat.head_tid;
                nest_next   = NEST_W'(1);
                woke        = 1'b1;
                st          = ST_HANDOFF;
            end
        end
    end

    // result fields from the state after this request
    always_comb
    begin
        res_next.status       = st;
        res_next.woken_valid  = woke;
        res_next.woken_thread = woke ? qstat.head_tid : '0;
        res_next.owner_valid  = held_next;
        res_next.owner_thread = held_next ? holder_next : '0;
        res_next.nest_count   = held_next ? NEST_OUT_W'(nest_next) : '0;
    end

    // lock state and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= 1'b0;
            holder_reg    <= '0;
            nest_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= req_valid;
            if (req_valid)
            begin
                held_reg   <= held_next;
                holder_reg <= holder_next;
                nest_reg   <= nest_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (req_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: hw/rtl/recursive_mutex_with_fifo_waiters_top.sv
// top level of the recursive mutex with a fifo of waiting threads
// depends on rmutex_pkg, rmutex_queue, rmutex_ctrl
//
// usage:
//   a request is action (0 acquire, 1 release) and thread_id, taken at a
//   rising edge where start is high and busy is low. busy never rises, so
//   a request may be issued in every cycle.
//   each request produces exactly one result: status, woken_valid,
//   woken_thread, owner_valid, owner_thread and nest_count, shown for one
//   cycle with done high. the receiver cannot stall; results must be
//   taken in the cycle they appear.
//   the request passes the input register, then one decision stage
//   into the result register, which drives done and the result.
//   throughput: one request per cycle; the decision reads the owner
//   registers and the prefetched head of the waiter memory, which is
//   read ahead at the next head address.
//   reset (rst_n low, asynchronous) frees the lock, empties the waiter
//   queue and clears all waiting bits; no clearing pass is needed, so
//   requests may start in the first cycle after reset.

module recursive_mutex_with_fifo_waiters_top #(
    parameter int THREAD_COUNT = 16,
    parameter int MAX_NESTING  = 255
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                action,
    input  logic [rmutex_pkg::TID_W-1:0]        thread_id,
    output logic                                done,
    output logic [rmutex_pkg::STATUS_W-1:0]     status,
    output logic                                woken_valid,
    output logic [rmutex_pkg::TID_W-1:0]        woken_thread,
    output logic                                owner_valid,
    output logic [rmutex_pkg::TID_W-1:0]        owner_thread,
    output logic [rmutex_pkg::NEST_OUT_W-1:0]   nest_count
);
    import rmutex_pkg::*;

    logic             req_valid_reg;
    logic             action_reg;
    logic [TID_W-1:0] tid_reg;
    queue_cmd_t       qcmd;
    queue_stat_t      qstat;
    result_t          res;

    // a request is taken in every cycle
    assign busy = 1'b0;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            action_reg <= action;
            tid_reg    <= thread_id;
        end
    end

    rmutex_queue #(
        .THREAD_COUNT (THREAD_COUNT)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (qcmd),
        .stat  (qstat)
    );

    rmutex_ctrl #(
        .THREAD_COUNT (THREAD_COUNT),
        .MAX_NESTING  (MAX_NESTING)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid_reg),
        .req_action (action_reg),
        .req_tid    (tid_reg),
        .qstat      (qstat),
        .qcmd       (qcmd),
        .res_valid  (done),
        .res        (res)
    );

    // result ports
    assign status       = res.status;
    assign woken_valid  = res.woken_valid;
    assign woken_thread = res.woken_thread;
    assign owner_valid  = res.owner_valid;
    assign owner_thread = res.owner_thread;
    assign nest_count   = res.nest_count;

endmodule

FILE: hw/rtl/rmutex_check.sv
// port-level checks for the recursive mutex top level, bound in below
// depends on rmutex_pkg and recursive_mutex_with_fifo_waiters_top

module rmutex_check (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              action,
    input  logic [rmutex_pkg::TID_W-1:0]      thread_id,
    input  logic                              done,
    input  logic [rmutex_pkg::STATUS_W-1:0]   status,
    input  logic                              woken_valid,
    input  logic [rmutex_pkg::TID_W-1:0]      woken_thread,
    input  logic                              owner_valid,
    input  logic [rmutex_pkg::TID_W-1:0]      owner_thread,
    input  logic [rmutex_pkg::NEST_OUT_W-1:0] nest_count
);
    import rmutex_pkg::*;

    // every accepted request yields a result through the input and result registers
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted request produced no result");

    // no result without an accepted request before it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without request");

    // a hand-off leaves the woken thread holding the lock once
    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (done && woken_valid) |-> (status == ST_HANDOFF) && owner_valid
            && (owner_thread == woken_thread) && (nest_count == 8'd1))
        else $error("hand-off result inconsistent");

    // a free lock reports no holder and no count
    a_free_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !owner_valid) |-> (owner_thread == '0) && (nest_count == '0))
        else $error("free lock shows holder data");

    // a grant goes to the requester of an acquire
    a_grant_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ((status == ST_GRANTED) || (status == ST_NESTED)))
            |-> owner_valid && (owner_thread == $past(thread_id, 2))
                && ($past(action, 2) == 1'b0))
        else $error("grant to wrong thread");

endmodule

bind recursive_mutex_with_fifo_waiters_top rmutex_check u_check (.*);
